@@ rtl/wavhp_pkg.sv @@
// ----------------------------------------------------------------------------
// wavhp_pkg
// Shared types and constants of the WAV header parser.
// ----------------------------------------------------------------------------
package wavhp_pkg;

	localparam logic [31:0] SIG_RIFF   = 32'h4646_4952;
	localparam logic [31:0] SIG_WAVE   = 32'h4556_4157;
	localparam logic [31:0] SIG_FMT    = 32'h2074_6D66;
	localparam logic [31:0] SIG_DATA   = 32'h6174_6164;
	localparam logic [31:0] FMT_MAX    = 32'h0001_FFFF;
	localparam logic [31:0] FMT_MIN    = 32'd16;
	localparam logic [31:0] MIN_LEN    = 32'd44;
	localparam logic [9:0]  MS_PER_S   = 10'd1000;
	localparam logic [41:0] DUR_MAX    = 42'h0_7FFF_FFFF;
	localparam int          DIV_W      = 42;
	localparam logic [5:0]  DIV_LAST   = 6'd41;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_SHORT     = 3'd1,
		STS_BAD_SIG   = 3'd2,
		STS_TRUNC     = 3'd3,
		STS_BAD_FMTLN = 3'd4,
		STS_UNSUPP    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PH_RIFF = 3'd0,
		PH_CHDR = 3'd1,
		PH_FMT  = 3'd2,
		PH_SKIP = 3'd3,
		PH_DONE = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'd0,
		SEQ_CH   = 2'd1,
		SEQ_RATE = 2'd2
	} seq_t;

	// parser context; all-zero is the cleared state
	typedef struct packed {
		phase_t       phase;
		logic [33:0]  pos;
		logic [31:0]  word;
		logic [31:0]  kind;
		logic [33:0]  cend;
		logic         fmt_seen;
		logic         data_seen;
		logic [15:0]  fmt_tag;
		logic [4:0]   bits;
		logic [31:0]  rate;
		logic [15:0]  chans;
		logic [33:0]  doff;
		logic [31:0]  dlen;
		logic [33:0]  fmt_base;
	} pctx_t;

	// verdict of one byte
	typedef struct packed {
		logic         valid;
		logic         ok;
		status_t      code;
		logic [4:0]   bits;
		logic [31:0]  rate;
		logic [15:0]  chans;
		logic [32:0]  doff;
		logic [31:0]  dlen;
	} pres_t;

endpackage

@@ rtl/wav_header_parser.sv @@
// ----------------------------------------------------------------------------
// wav_header_parser
// RIFF/WAVE PCM header parser with an iterative duration divider.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_*       in   tdata: byte_value; tuser: new_file; tlast: last_byte
// m_*       out  tuser: status; tdata: bits,rate,channels,offset,length,ms
// apb       in   resource_length at address 0
//
// A success with a usable rate and channel count runs two 42-step divisions
// on the shared divider (by channels, then by rate) with the input held off.
// Failures, and successes without divisions, are registered the same cycle.
// arst_n clears the parser, sequencer and output valid; resource_length = 0.
// Input stalls only while the divider runs or the output register is held.
// ----------------------------------------------------------------------------
module wav_header_parser import wavhp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] byte_value
	input  logic [0:0]   s_tuser,   // [0] new_file
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [4:0] sample_bits, [36:5] sample_rate, [52:37] channel_count,
	// [85:53] data_offset, [117:86] data_length, [148:118] duration_ms
	output logic [151:0] m_tdata,
	output logic [2:0]   m_tuser,   // [2:0] status
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [31:0]      rlen_q;
	logic             take;
	pres_t            res;
	seq_t             seq_q, seq_d;
	logic             div_start, div_done;
	logic [DIV_W-1:0] div_dvd, div_q;
	logic [31:0]      div_dvs;
	logic [41:0]      prod;
	logic             dur_ok;
	logic             load_fail, load_now, load_div;
	logic [4:0]       bits_q;
	logic [31:0]      rate_q;
	logic [15:0]      chans_q;
	logic [32:0]      doff_q;
	logic [31:0]      dlen_q;
	logic             ov_q;
	logic [151:0]     od_q;
	status_t          os_q;
	logic [30:0]      dur_sat;

	// APB
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? rlen_q : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rlen_q <= '0;
		else if (psel && penable && pwrite && paddr == 3'd0)
			rlen_q <= pwdata;
	end

	assign s_tready = (seq_q == SEQ_IDLE) && (!ov_q || m_tready);
	assign take     = s_tvalid && s_tready;

	wavhp_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.byte_value      (s_tdata),
		.new_file        (s_tuser[0]),
		.last_byte       (s_tlast),
		.resource_length (rlen_q),
		.res             (res)
	);

	assign prod   = {10'b0, res.dlen} * {32'b0, MS_PER_S};
	assign dur_ok = res.rate != 32'd0 && !res.rate[31] && res.chans != 16'd0;

	wavhp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	// sequencer next state
	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			SEQ_IDLE: if (res.valid && res.ok && dur_ok) seq_d = SEQ_CH;
			SEQ_CH:   if (div_done) seq_d = SEQ_RATE;
			SEQ_RATE: if (div_done) seq_d = SEQ_IDLE;
			default:  seq_d = SEQ_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		load_fail = 1'b0;
		load_now  = 1'b0;
		load_div  = 1'b0;
		case (seq_q)
			SEQ_IDLE: begin
				load_fail = res.valid && !res.ok;
				load_now  = res.valid && res.ok && !dur_ok;
				div_start = res.valid && res.ok && dur_ok;
				div_dvd   = res.bits[4] ? {1'b0, prod[41:1]} : prod;
				div_dvs   = {16'b0, res.chans};
			end
			SEQ_CH: begin
				div_start = div_done;
				div_dvd   = div_q;
				div_dvs   = rate_q;
			end
			SEQ_RATE: load_div = div_done;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seq_q <= SEQ_IDLE;
		else
			seq_q <= seq_d;
	end

	always_ff @(posedge clk) begin
		if (div_start && seq_q == SEQ_IDLE) begin
			bits_q  <= res.bits;
			rate_q  <= res.rate;
			chans_q <= res.chans;
			doff_q  <= res.doff;
			dlen_q  <= res.dlen;
		end
	end

	assign dur_sat = (div_q > DUR_MAX) ? DUR_MAX[30:0] : div_q[30:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (load_fail || load_now || load_div)
			ov_q <= 1'b1;
		else if (m_tready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_fail) begin
			os_q <= res.code;
			od_q <= '0;
		end else if (load_now) begin
			os_q <= STS_OK;
			od_q <= {3'b0, 31'd0, res.dlen, res.doff, res.chans, res.rate, res.bits};
		end else if (load_div) begin
			os_q <= STS_OK;
			od_q <= {3'b0, dur_sat, dlen_q, doff_q, chans_q, rate_q, bits_q};
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;
	assign m_tuser  = os_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		seq_q != SEQ_IDLE |-> !s_tready)
		else $error("input taken during division");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> seq_q == SEQ_CH || seq_q == SEQ_RATE)
		else $error("divider finished outside a division");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STS_OK |-> m_tdata == '0)
		else $error("failure result carries payload");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STS_OK |-> m_tdata[4:0] == 5'd8 || m_tdata[4:0] == 5'd16)
		else $error("success with bad sample size");

endmodule

@@ rtl/wavhp_div.sv @@
// ----------------------------------------------------------------------------
// wavhp_div
// Restoring divider, one quotient bit per cycle, 42-bit dividend.
// ----------------------------------------------------------------------------
module wavhp_div import wavhp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [31:0]       divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quotient
);

	logic [DIV_W-1:0] dq_q;
	logic [31:0]      rem_q;
	logic [31:0]      dvs_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [32:0]      sh;
	logic [32:0]      diff;
	logic             ge;

	assign sh   = {rem_q, dq_q[DIV_W-1]};
	assign ge   = sh >= {1'b0, dvs_q};
	assign diff = sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == DIV_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : sh[31:0];
			dq_q  <= {dq_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

@@ rtl/wavhp_parser.sv @@
// ----------------------------------------------------------------------------
// wavhp_parser
// Byte-wise RIFF/WAVE chunk walker; one byte per accepted transaction.
// ----------------------------------------------------------------------------
module wavhp_parser import wavhp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  byte_value,
	input  logic        new_file,
	input  logic        last_byte,
	input  logic [31:0] resource_length,
	output pres_t       res
);

	pctx_t       ctx_q;
	pctx_t       cur;
	pctx_t       nxt;
	logic [33:0] nextp;
	logic [31:0] word_n;
	logic [33:0] k;
	logic [33:0] kf;
	logic [34:0] span;
	logic [31:0] len;
	logic        hit;
	logic        hit_ok;
	status_t     hit_code;

	assign cur    = new_file ? '0 : ctx_q;
	assign nextp  = cur.pos + 34'd1;
	assign word_n = {byte_value, cur.word[31:8]};
	assign k      = cur.pos - cur.cend;
	assign kf     = cur.pos - cur.fmt_base;
	assign span   = {1'b0, nextp} + {3'b0, word_n};

	always_comb begin
		nxt      = cur;
		hit      = 1'b0;
		hit_ok   = 1'b0;
		hit_code = STS_OK;
		len      = word_n;
		if (span > {3'b0, resource_length})
			len = ({2'b0, resource_length} > nextp) ?
				resource_length - nextp[31:0] : 32'd0;
		if (cur.phase != PH_DONE) begin
			nxt.pos  = nextp;
			nxt.word = word_n;
			case (cur.phase)
				PH_RIFF: begin
					if (cur.pos == '0 && resource_length <= MIN_LEN) begin
						hit = 1'b1; hit_code = STS_SHORT;
					end else if (cur.pos == 34'd3) begin
						nxt.kind = word_n;
					end else if (cur.pos >= 34'd11) begin
						if (cur.kind != SIG_RIFF || word_n != SIG_WAVE) begin
							hit = 1'b1; hit_code = STS_BAD_SIG;
						end else begin
							nxt.phase = PH_CHDR;
							nxt.cend  = nextp;
						end
					end
				end
				PH_CHDR: begin
					if (k == 34'd3) begin
						nxt.kind = word_n;
					end else if (k >= 34'd7) begin
						nxt.cend  = nextp + {2'b0, len};
						nxt.phase = (nextp == nxt.cend) ? PH_CHDR : PH_SKIP;
						if (cur.kind == SIG_FMT && !cur.fmt_seen) begin
							nxt.fmt_seen = 1'b1;
							if (len < FMT_MIN || len > FMT_MAX) begin
								hit = 1'b1; hit_code = STS_BAD_FMTLN;
							end else begin
								nxt.phase    = PH_FMT;
								nxt.fmt_base = nextp;
							end
						end else if (cur.kind == SIG_DATA && !cur.data_seen) begin
							nxt.data_seen = 1'b1;
							nxt.doff      = nextp;
							nxt.dlen      = len;
							if (cur.fmt_seen) begin
								hit = 1'b1; hit_ok = 1'b1;
							end
						end
					end
				end
				PH_FMT: begin
					if (kf == 34'd1) begin
						nxt.fmt_tag = word_n[31:16];
					end else if (kf == 34'd3) begin
						nxt.chans = word_n[31:16];
					end else if (kf == 34'd7) begin
						nxt.rate = word_n;
					end else if (kf >= 34'd15) begin
						if (cur.fmt_tag != 16'd1 ||
						    (word_n[31:16] != 16'd8 && word_n[31:16] != 16'd16)) begin
							hit = 1'b1; hit_code = STS_UNSUPP;
						end else begin
							nxt.bits  = word_n[20:16];
							nxt.phase = (nextp == cur.cend) ? PH_CHDR : PH_SKIP;
							if (cur.data_seen) begin
								hit = 1'b1; hit_ok = 1'b1;
							end
						end
					end
				end
				PH_SKIP: begin
					if (nextp == cur.cend)
						nxt.phase = PH_CHDR;
				end
				default: ;
			endcase
			if (!hit && last_byte) begin
				hit = 1'b1; hit_code = STS_TRUNC;
			end
			if (hit)
				nxt.phase = PH_DONE;
		end
	end

	always_comb begin
		res       = '0;
		res.valid = take && hit;
		res.ok    = hit_ok;
		res.code  = hit_code;
		if (hit_ok) begin
			res.bits  = nxt.bits;
			res.rate  = nxt.rate;
			res.chans = nxt.chans;
			res.doff  = nxt.doff[32:0];
			res.dlen  = nxt.dlen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctx_q <= '0;
		else if (take)
			ctx_q <= nxt;
	end

	// a verdict always parks the parser until the next new_file
	assert property (@(posedge clk) disable iff (!arst_n)
		take && hit |=> ctx_q.phase == PH_DONE)
		else $error("verdict without done phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		take && !new_file && ctx_q.phase == PH_DONE |-> !hit)
		else $error("second verdict for one resource");
	assert property (@(posedge clk) disable iff (!arst_n)
		hit && hit_ok |-> nxt.fmt_seen && nxt.data_seen)
		else $error("success before both chunks");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for wav_header_parser: streams WAV headers (well-formed,
// broken and noise) over the byte stream, predicts each verdict and compares
// every output field. The resource length register is rewritten between groups of resources.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import wavhp_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [151:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	typedef struct packed {
		status_t     code;
		logic [4:0]  bits;
		logic [31:0] rate;
		logic [15:0] chans;
		logic [32:0] doff;
		logic [31:0] dlen;
		logic [30:0] ms;
	} verdict_t;

	verdict_t verdict_q[$];
	int mismatches = 0;
	int verdicts_checked = 0;
	int bytes_sent = 0;
	int idle_cycles = 0;
	bit rx_stall_on = 1'b1;

	// predictor state
	logic [31:0] p_reslen;
	phase_t      p_phase;
	logic [33:0] p_pos;
	logic [31:0] p_word;
	logic [31:0] p_kind;
	logic [33:0] p_cend;
	logic        p_fmt_seen, p_data_seen, p_done;
	logic [15:0] p_tag;
	logic [4:0]  p_bits;
	logic [31:0] p_rate;
	logic [15:0] p_chans;
	logic [33:0] p_doff;
	logic [31:0] p_dlen;
	logic [33:0] p_fbase;

	wav_header_parser dut (.*);

	always #4 clk = ~clk;

	function automatic void parser_clear();
		p_phase = PH_RIFF; p_pos = '0; p_word = '0; p_kind = '0; p_cend = '0;
		p_fmt_seen = 0; p_data_seen = 0; p_done = 0; p_tag = '0; p_bits = '0;
		p_rate = '0; p_chans = '0; p_doff = '0; p_dlen = '0; p_fbase = '0;
	endfunction

	function automatic verdict_t fail_verdict(status_t c);
		verdict_t v;
		v = '0;
		v.code = c;
		return v;
	endfunction

	function automatic verdict_t ok_verdict();
		verdict_t v;
		logic [63:0] d;
		logic [63:0] bps;
		v = '0;
		d = 0;
		if (p_rate > 0 && p_rate < 32'h8000_0000 && p_chans > 0) begin
			bps = p_bits / 8;
			if (bps == 0) bps = 1;
			d = 64'(p_dlen) * 1000;
			d = d / bps / p_chans / p_rate;
			if (d > 64'h7FFF_FFFF) d = 64'h7FFF_FFFF;
		end
		v.code = STS_OK; v.bits = p_bits; v.rate = p_rate; v.chans = p_chans;
		v.doff = p_doff[32:0]; v.dlen = p_dlen; v.ms = d[30:0];
		return v;
	endfunction

	// advances the predictor by one byte; returns 1 with a verdict if one is due
	function automatic bit parse_byte(logic [7:0] b, bit nf, bit last, output verdict_t v);
		logic [33:0] pos, nxt, k;
		logic [35:0] len;
		bit got;
		got = 0;
		v = '0;
		if (nf) parser_clear();
		if (p_done) return 0;
		pos = p_pos;
		nxt = pos + 1;
		p_pos = nxt;
		p_word = {b, p_word[31:8]};
		case (p_phase)
			PH_RIFF: begin
				if (pos == 0 && p_reslen <= MIN_LEN) begin
					v = fail_verdict(STS_SHORT); got = 1;
				end else if (pos == 3) begin
					p_kind = p_word;
				end else if (pos >= 11) begin
					if (p_kind != SIG_RIFF || p_word != SIG_WAVE) begin
						v = fail_verdict(STS_BAD_SIG); got = 1;
					end else begin
						p_phase = PH_CHDR; p_cend = nxt;
					end
				end
			end
			PH_CHDR: begin
				k = pos - p_cend;
				if (k == 3) begin
					p_kind = p_word;
				end else if (k >= 7) begin
					len = p_word;
					if (36'(nxt) + len > 36'(p_reslen))
						len = (36'(p_reslen) > 36'(nxt)) ? 36'(p_reslen) - 36'(nxt) : 0;
					p_cend = nxt + len[33:0];
					if (p_kind == SIG_FMT && !p_fmt_seen) begin
						p_fmt_seen = 1;
						if (len < 16 || len > 36'h1FFFF) begin
							v = fail_verdict(STS_BAD_FMTLN); got = 1;
						end else begin
							p_phase = PH_FMT; p_fbase = nxt;
						end
					end else if (p_kind == SIG_DATA && !p_data_seen) begin
						p_data_seen = 1; p_doff = nxt; p_dlen = len[31:0];
						if (p_fmt_seen) begin
							v = ok_verdict(); got = 1;
						end else p_phase = (nxt == p_cend) ? PH_CHDR : PH_SKIP;
					end else p_phase = (nxt == p_cend) ? PH_CHDR : PH_SKIP;
				end
			end
			PH_FMT: begin
				k = pos - p_fbase;
				if (k == 1) p_tag = p_word[31:16];
				else if (k == 3) p_chans = p_word[31:16];
				else if (k == 7) p_rate = p_word;
				else if (k >= 15) begin
					if (p_tag != 1 || (p_word[31:16] != 8 && p_word[31:16] != 16)) begin
						v = fail_verdict(STS_UNSUPP); got = 1;
					end else begin
						p_bits = p_word[20:16];
						if (p_data_seen) begin
							v = ok_verdict(); got = 1;
						end else p_phase = (nxt == p_cend) ? PH_CHDR : PH_SKIP;
					end
				end
			end
			PH_SKIP: if (nxt == p_cend) p_phase = PH_CHDR;
			default: ;
		endcase
		if (!got && last) begin
			v = fail_verdict(STS_TRUNC); got = 1;
		end
		if (got) p_done = 1;
		return got;
	endfunction

	task automatic random_gap(int pct);
		int n;
		if ($urandom_range(99) < pct) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(40, 5) : $urandom_range(3, 1);
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// sends one byte and records any verdict it causes
	task automatic send_byte(logic [7:0] b, bit nf, bit last, int gap_pct = 20);
		verdict_t v;
		random_gap(gap_pct);
		s_tvalid <= 1'b1; s_tdata <= b; s_tuser <= nf; s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (parse_byte(b, nf, last, v)) verdict_q.push_back(v);
		bytes_sent++;
	endtask

	task automatic send_word(logic [31:0] w, int gap_pct = 20);
		for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8], 0, 0, gap_pct);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reslen(logic [31:0] val);
		wait_idle();
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= '0; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		p_reslen = val;
		@(posedge clk);
	endtask

	// one resource: header, optional junk chunks, fmt and data in random order
	task automatic send_wav(bit broken);
		logic [31:0] flen, rate, dlen;
		logic [15:0] tag, ch, bits;
		int njunk, jl, stop;
		bit data_first;
		logic [7:0] hdr[$];
		logic [31:0] w;
		hdr = {};
		flen = ($urandom_range(7) == 0) ? $urandom_range(40, 0) : (16 + 2 * $urandom_range(3));
		tag = ($urandom_range(15) == 0) ? 16'($urandom) : 16'd1;
		ch = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(8));
		case ($urandom_range(3))
			0: rate = $urandom;
			1: rate = 32'hFFFF_FFFF - $urandom_range(3);
			default: rate = $urandom_range(192000);
		endcase
		bits = ($urandom_range(9) == 0) ? 16'($urandom_range(32)) :
			($urandom_range(1) ? 16'd16 : 16'd8);
		dlen = $urandom_range(1) ? $urandom : $urandom_range(100000);
		data_first = ($urandom_range(5) == 0);
		njunk = $urandom_range(2);
		w = $urandom_range(5) == 0 ? $urandom : SIG_RIFF;
		for (int i = 0; i < 4; i++) hdr.push_back(w[8*i +: 8]);
		w = $urandom;
		for (int i = 0; i < 4; i++) hdr.push_back(w[8*i +: 8]);
		w = $urandom_range(5) == 0 ? $urandom : SIG_WAVE;
		for (int i = 0; i < 4; i++) hdr.push_back(w[8*i +: 8]);
		for (int j = 0; j < njunk; j++) begin
			jl = $urandom_range(6);
			w = $urandom_range(3) == 0 ? SIG_DATA - 1 : $urandom;
			for (int i = 0; i < 4; i++) hdr.push_back(w[8*i +: 8]);
			for (int i = 0; i < 4; i++) hdr.push_back(8'(jl >> (8*i)));
			repeat (jl) hdr.push_back(8'($urandom));
		end
		for (int c = 0; c < 2; c++) begin
			if ((c == 0) != data_first) begin
				w = SIG_FMT;
				for (int i = 0; i < 4; i++) hdr.push_back(w[8*i +: 8]);
				for (int i = 0; i < 4; i++) hdr.push_back(flen[8*i +: 8]);
				hdr.push_back(tag[7:0]); hdr.push_back(tag[15:8]);
				hdr.push_back(ch[7:0]); hdr.push_back(ch[15:8]);
				for (int i = 0; i < 4; i++) hdr.push_back(rate[8*i +: 8]);
				repeat (6) hdr.push_back(8'($urandom));
				hdr.push_back(bits[7:0]); hdr.push_back(bits[15:8]);
				for (int i = 16; i < flen; i++) hdr.push_back(8'($urandom));
			end else begin
				w = SIG_DATA;
				for (int i = 0; i < 4; i++) hdr.push_back(w[8*i +: 8]);
				for (int i = 0; i < 4; i++) hdr.push_back(dlen[8*i +: 8]);
				if (data_first) repeat ($urandom_range(4)) hdr.push_back(8'($urandom));
			end
		end
		stop = broken ? $urandom_range(hdr.size() - 1) : hdr.size() - 1;
		foreach (hdr[i]) begin
			if (i > stop) break;
			send_byte(hdr[i], i == 0, (i == stop) && broken, $urandom_range(1) ? 0 : 25);
		end
	endtask

	task automatic test_directed();
		write_reslen(32'd44);
		send_byte(8'h00, 1, 0);               // too short
		write_reslen(32'd45);
		send_byte(8'hFF, 1, 0);
		for (int i = 1; i < 12; i++) send_byte(8'h5A, 0, i == 11); // bad signature
		send_byte(8'h52, 1, 1);               // truncated on the first byte
		send_byte(8'h52, 0, 1);               // ignored after verdict
		write_reslen(32'hFFFF_FFFF);
		send_wav(0);
		write_reslen(32'd60);                 // clamps chunk lengths
		send_wav(0);
	endtask

	task automatic test_random(int n_items);
		logic [31:0] rl;
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_items) begin
			case ($urandom_range(5))
				0: rl = 32'hFFFF_FFFF;
				1: rl = $urandom_range(200, 44);
				2: rl = $urandom;
				default: rl = $urandom_range(1000000, 45);
			endcase
			write_reslen(rl);
			for (int r = 0; r < 6; r++) begin
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(8)) send_byte(8'($urandom),
						1'($urandom_range(1)), 1'($urandom_range(1)));
				else
					send_wav($urandom_range(3) == 0);
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		verdict_t got, want;
		if (m_tvalid && m_tready) begin
			got = {status_t'(m_tuser), m_tdata[4:0], m_tdata[36:5], m_tdata[52:37],
				m_tdata[85:53], m_tdata[117:86], m_tdata[148:118]};
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected verdict %p", got);
			end else begin
				want = verdict_q.pop_front();
				verdicts_checked++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		m_tready <= rx_stall_on ? ($urandom_range(4) != 0) : 1'b1;
		if ($urandom_range(199) == 0) rx_stall_on <= ~rx_stall_on;
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		p_reslen = '0;
		parser_clear();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1750);
		wait_idle();
		$display("sent %0d bytes, checked %0d verdicts, %0d mismatches",
			bytes_sent, verdicts_checked, mismatches);
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
